[hw/rtl/cmm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmm_pkg: shared types and constants of the counter mix generator
// Holds the item kinds, the mixer step codes, the mixing constants and the
// helper functions of one mixing round.
// ----------------------------------------------------------------------------
package cmm_pkg;

  // Item kinds of the input words.
  typedef enum logic [0:0] {
    KIND_DRAW = 1'b0,
    KIND_SEED = 1'b1
  } kind_t;

  // Steps of the mixing sequencer.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_B,
    ST_R1_MUL1,
    ST_R1_MUL2,
    ST_MUL_C,
    ST_R2_MUL1,
    ST_R2_MUL2,
    ST_FINISH
  } mix_state_t;

  localparam int unsigned WORD_W = 32;

  // Depth of the queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [WORD_W-1:0] MIX_MUL_ONE = 32'h85EB_CA6B;
  localparam logic [WORD_W-1:0] MIX_MUL_TWO = 32'hC2B2_AE35;
  localparam logic [WORD_W-1:0] ROUND_A_OFS = 32'h3D48_5453;
  localparam logic [WORD_W-1:0] ROUND_B_MUL = 32'h9E37_79B9;
  localparam logic [WORD_W-1:0] ROUND_C_MUL = 32'h6C62_272E;

  // Rotate left by 13.
  function automatic logic [WORD_W-1:0] rotl13(input logic [WORD_W-1:0] x);
    return {x[WORD_W-14:0], x[WORD_W-1:WORD_W-13]};
  endfunction

  // Xor with itself shifted right by 16.
  function automatic logic [WORD_W-1:0] xshift16(input logic [WORD_W-1:0] x);
    return x ^ (x >> 16);
  endfunction

  // Product modulo 2^32.
  function automatic logic [WORD_W-1:0] mul_lo(input logic [WORD_W-1:0] x,
                                              input logic [WORD_W-1:0] k);
    logic [2*WORD_W-1:0] p;
    p = {{WORD_W{1'b0}}, x} * {{WORD_W{1'b0}}, k};
    return p[WORD_W-1:0];
  endfunction

  // One full mixing round; used only for elaboration-time constants.
  function automatic logic [WORD_W-1:0] mix_round(input logic [WORD_W-1:0] x,
                                                 input logic [WORD_W-1:0] y);
    logic [WORD_W-1:0] s;
    s = rotl13(x ^ y);
    s = xshift16(mul_lo(s, MIX_MUL_ONE));
    s = xshift16(mul_lo(s, MIX_MUL_TWO));
    return s;
  endfunction

  // The first round mixes (c ^ offset) with c, so c cancels and the round
  // result is the same for every draw.
  localparam logic [WORD_W-1:0] ROUND_A_WORD = mix_round(ROUND_A_OFS, 32'h0000_0000);

endpackage
`default_nettype wire

[hw/rtl/cmm_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmm_front: input side of the counter mix generator
// Accepts words, applies the one-time seed, steps the nonce counter and hands
// the combined value of each draw to the queue.
// ----------------------------------------------------------------------------
module cmm_front
  import cmm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire logic              kind,
  input  wire logic [WORD_W-1:0] entropy_word,
  output logic                   full,
  input  wire logic              q_full,
  output logic                   q_push,
  output logic [WORD_W-1:0]      q_data
);

  logic [WORD_W-1:0] nonce_counter;
  logic              seeded_flag;
  logic              accept;
  logic              is_seed;

  // Every word waits on queue space, so the handshake stays simple.
  assign full    = q_full;
  assign accept  = push && !q_full;
  assign is_seed = (kind == KIND_SEED);

  // A draw sends the old counter mixed with its entropy word.
  assign q_push = accept && !is_seed;
  assign q_data = nonce_counter ^ entropy_word;

  // Counter and seed flag update.
  always_ff @(posedge clk) begin
    if (rst) begin
      nonce_counter <= {{(WORD_W-1){1'b0}}, 1'b1};
      seeded_flag   <= 1'b0;
    end else if (accept) begin
      if (is_seed) begin
        if (!seeded_flag) begin
          nonce_counter <= nonce_counter ^ entropy_word;
          seeded_flag   <= 1'b1;
        end
      end else begin
        nonce_counter <= nonce_counter + {{(WORD_W-1){1'b0}}, 1'b1};
      end
    end
  end

endmodule
`default_nettype wire

[hw/rtl/cmm_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmm_queue: short queue between front and back
// Holds combined draw values so that the front and the mixer stall apart.
// ----------------------------------------------------------------------------
module cmm_queue
  import cmm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              wr_en,
  input  wire logic [WORD_W-1:0] wr_data,
  output logic                   q_full,
  input  wire logic              rd_en,
  output logic                   rd_valid,
  output logic [WORD_W-1:0]      rd_data
);

  logic [WORD_W-1:0]      slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;
  logic                   do_wr;
  logic                   do_rd;

  assign q_full   = (count == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = slots[rd_ptr];
  assign do_wr    = wr_en && !q_full;
  assign do_rd    = rd_en && rd_valid;

  // Storage write.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

[hw/rtl/cmm_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmm_back: mixing sequencer and result register
// Runs the two data-dependent mixing rounds on one shared 32x32 multiplier,
// one product per cycle, and holds the finished word for the consumer.
// ----------------------------------------------------------------------------
module cmm_back
  import cmm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_valid,
  input  wire logic [WORD_W-1:0] q_data,
  output logic                   q_pop,
  output logic                   empty,
  input  wire logic              pop,
  output logic [WORD_W-1:0]      random_word
);

  mix_state_t        state;
  mix_state_t        state_next;
  logic [WORD_W-1:0] c_word;
  logic [WORD_W-1:0] prod;
  logic [WORD_W-1:0] prod_next;
  logic [WORD_W-1:0] b_word;
  logic [WORD_W-1:0] mul_op;
  logic [WORD_W-1:0] mul_k;
  logic              prod_load;
  logic              out_valid;
  logic              out_load;
  logic              out_taken;

  assign empty     = !out_valid;
  assign out_taken = pop && out_valid;

  // The single multiplier; its product is registered before any further use.
  assign prod_next = WORD_W'(mul_op * mul_k);

  // Step sequencing and multiplier operand selection.
  always_comb begin
    state_next = state;
    mul_op     = c_word;
    mul_k      = MIX_MUL_ONE;
    prod_load  = 1'b0;
    q_pop      = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = ST_MUL_B;
        end
      end
      ST_MUL_B: begin
        mul_op     = c_word;
        mul_k      = ROUND_B_MUL;
        prod_load  = 1'b1;
        state_next = ST_R1_MUL1;
      end
      ST_R1_MUL1: begin
        mul_op     = rotl13(ROUND_A_WORD ^ prod ^ ~c_word);
        mul_k      = MIX_MUL_ONE;
        prod_load  = 1'b1;
        state_next = ST_R1_MUL2;
      end
      ST_R1_MUL2: begin
        mul_op     = xshift16(prod);
        mul_k      = MIX_MUL_TWO;
        prod_load  = 1'b1;
        state_next = ST_MUL_C;
      end
      ST_MUL_C: begin
        mul_op     = c_word;
        mul_k      = ROUND_C_MUL;
        prod_load  = 1'b1;
        state_next = ST_R2_MUL1;
      end
      ST_R2_MUL1: begin
        mul_op     = rotl13(b_word ^ prod ^ c_word ^ ROUND_A_WORD);
        mul_k      = MIX_MUL_ONE;
        prod_load  = 1'b1;
        state_next = ST_R2_MUL2;
      end
      ST_R2_MUL2: begin
        mul_op     = xshift16(prod);
        mul_k      = MIX_MUL_TWO;
        prod_load  = 1'b1;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        // Wait here while the previous word is still unread.
        if (!out_valid || pop) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      c_word <= q_data;
    end
    if (prod_load) begin
      prod <= prod_next;
    end
    if (state == ST_MUL_C) begin
      b_word <= xshift16(prod);
    end
    if (out_load) begin
      random_word <= ROUND_A_WORD ^ b_word ^ xshift16(prod);
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_taken) begin
      out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/counter_murmur_mix_rng.sv]
// A draw word passes the front, the queue and the mixer's steps before it shows
// on random_word; seed words never give a result. The mixer takes one draw at a
// time on its single shared multiplier, which does six products per draw plus
// a load and a finish step; pending draws wait in the queue.
// Reset: synchronous; the nonce counter returns to one, the seed flag clears,
// and the queue and result register empty.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// counter_murmur_mix_rng: counter-based pseudo-random word generator
// A front stage keeps the seeded nonce counter, a short queue carries each
// draw value, and a sequenced mixer produces the random word.
// ----------------------------------------------------------------------------
module counter_murmur_mix_rng
  import cmm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire logic              kind,
  input  wire logic [WORD_W-1:0] entropy_word,
  output logic                   full,
  output logic                   empty,
  input  wire logic              pop,
  output logic [WORD_W-1:0]      random_word
);

  logic              q_full;
  logic              q_push;
  logic [WORD_W-1:0] q_wdata;
  logic              q_valid;
  logic [WORD_W-1:0] q_rdata;
  logic              q_pop;

  // Front: counter, seed and draw classification.
  cmm_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .kind         (kind),
    .entropy_word (entropy_word),
    .full         (full),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (q_wdata)
  );

  // Queue of pending draw values.
  cmm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (q_push),
    .wr_data  (q_wdata),
    .q_full   (q_full),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_data  (q_rdata)
  );

  // Back: mixing rounds and result word.
  cmm_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_data      (q_rdata),
    .q_pop       (q_pop),
    .empty       (empty),
    .pop         (pop),
    .random_word (random_word)
  );

endmodule
`default_nettype wire

[hw/rtl/cmm_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmm_checker: port-level checks for the counter mix generator
// Tracks accepted draws against taken words and watches the result port.
// ----------------------------------------------------------------------------
module cmm_checker
  import cmm_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              push,
  input wire logic              kind,
  input wire logic              full,
  input wire logic              empty,
  input wire logic              pop,
  input wire logic [WORD_W-1:0] random_word
);

  logic [3:0] outstanding;
  logic [3:0] outstanding_next;
  logic       draw_in;
  logic       word_out;

  assign draw_in  = push && !full && (kind == KIND_DRAW);
  assign word_out = pop && !empty;

  // Count of accepted draws whose word has not been taken yet.
  always_comb begin
    outstanding_next = outstanding;
    if (draw_in && !word_out) begin
      outstanding_next = outstanding + 4'd1;
    end else if (word_out && !draw_in) begin
      outstanding_next = outstanding - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= 4'd0;
    end else begin
      outstanding <= outstanding_next;
    end
  end

  // A waiting word stays until it is taken.
  a_word_held: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty)
    else $error("result word dropped before it was taken");

  // A waiting word does not change.
  a_word_stable: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> $stable(random_word))
    else $error("result word changed while waiting");

  // No word appears without a draw behind it; seeds give none.
  a_no_extra_word: assert property (@(posedge clk) disable iff (rst)
    outstanding == 4'd0 |-> empty)
    else $error("result word without a pending draw");

  // Reset empties the result side.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> empty)
    else $error("result side not empty after reset");

endmodule

bind counter_murmur_mix_rng cmm_checker u_cmm_checker (
  .clk         (clk),
  .rst         (rst),
  .push        (push),
  .kind        (kind),
  .full        (full),
  .empty       (empty),
  .pop         (pop),
  .random_word (random_word)
);
`default_nettype wire
